### sv/mcops_pkg.sv
// shared types and constants for the most-credit output port selector
// no dependencies; used by mcops_ctrl, mcops_datapath and the top level
package mcops_pkg;

    // fixed widths of the item fields
    localparam int CAND_W   = 5;
    localparam int ELIG_W   = 20;
    localparam int PORT_W   = 3;
    localparam int VC_W     = 2;
    localparam int CRED_W   = 5;
    localparam int BEST_W   = 7;
    localparam int BEST_MAX = 127;

    // action codes
    localparam logic ACT_SELECT = 1'b0;
    localparam logic ACT_STATUS = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic write;   // rewrite one channel entry
        logic load;    // capture a select beat, clear the running best
        logic step;    // evaluate one port, advance the port counter
        logic emit;    // register the result and raise the strobe
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;    // port counter is on the last port
    } t_dp_stat;

endpackage

### sv/mcops_ctrl.sv
// controller state machine for the most-credit output port selector
// depends on mcops_pkg (state enum, command and status structs)
module mcops_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_action,
    input  mcops_pkg::t_dp_stat i_stat,
    output mcops_pkg::t_dp_cmd  o_cmd,
    output logic                o_busy
);

    mcops_pkg::t_state r_state;
    mcops_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcops_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mcops_pkg::ST_IDLE: begin
                if (i_start && i_action == mcops_pkg::ACT_SELECT) begin
                    n_state = mcops_pkg::ST_SCAN;
                end
            end
            mcops_pkg::ST_SCAN: begin
                if (i_stat.last) begin
                    n_state = mcops_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mcops_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b0;
        case (r_state)
            mcops_pkg::ST_IDLE: begin
                o_cmd.write = i_start && i_action == mcops_pkg::ACT_STATUS;
                o_cmd.load  = i_start && i_action == mcops_pkg::ACT_SELECT;
            end
            mcops_pkg::ST_SCAN: begin
                o_busy     = 1'b1;
                o_cmd.step = 1'b1;
                o_cmd.emit = i_stat.last;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

endmodule

### sv/mcops_datapath.sv
// datapath for the most-credit output port selector: channel store,
// per-port credit sum, running best compare and result registers; uses mcops_pkg
module mcops_datapath #(
    parameter int NUM_PORTS   = 5,
    parameter int NUM_VCS     = 4,
    parameter int MAX_CREDITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mcops_pkg::t_dp_cmd                  i_cmd,
    output mcops_pkg::t_dp_stat                 o_stat,
    input  logic [mcops_pkg::CAND_W-1:0]        i_port_candidates,
    input  logic [mcops_pkg::ELIG_W-1:0]        i_vc_eligible,
    input  logic [mcops_pkg::PORT_W-1:0]        i_status_port,
    input  logic [mcops_pkg::VC_W-1:0]          i_status_vc,
    input  logic                                i_status_avail,
    input  logic [mcops_pkg::CRED_W-1:0]        i_status_credits,
    output logic                                o_strobe,
    output logic [mcops_pkg::PORT_W-1:0]        o_chosen_port,
    output logic [mcops_pkg::BEST_W-1:0]        o_best_credits,
    output logic                                o_no_candidate
);

    localparam int CHANNELS   = NUM_PORTS * NUM_VCS;
    localparam int PW         = $clog2(NUM_PORTS);
    localparam int CAND_EXT_W = (NUM_PORTS > mcops_pkg::CAND_W) ? NUM_PORTS : mcops_pkg::CAND_W;
    localparam int ELIG_EXT_W = (CHANNELS > mcops_pkg::ELIG_W) ? CHANNELS : mcops_pkg::ELIG_W;
    localparam int CRED_MAX   = (1 << mcops_pkg::CRED_W) - 1;
    localparam int SUM_W      = $clog2(NUM_VCS * CRED_MAX + 1);

    // channel store, one row per port
    logic [mcops_pkg::CRED_W-1:0] r_cred [NUM_PORTS][NUM_VCS];
    logic [NUM_VCS-1:0]           r_avail [NUM_PORTS];

    // captured select beat and running best
    logic [NUM_PORTS-1:0] r_cand;
    logic [NUM_VCS-1:0]   r_elig [NUM_PORTS];
    logic [PW-1:0]        r_port;
    logic                 r_found;
    logic [PW-1:0]        r_best_port;
    logic [SUM_W-1:0]     r_best_sum;

    logic                         r_strobe;
    logic [mcops_pkg::PORT_W-1:0] r_chosen;
    logic [mcops_pkg::BEST_W-1:0] r_best_out;
    logic                         r_none;

    logic [CAND_EXT_W-1:0]        cand_ext;
    logic [ELIG_EXT_W-1:0]        elig_ext;
    logic [mcops_pkg::CRED_W-1:0] wr_cred;
    logic [SUM_W-1:0]             port_sum;
    logic                         take;
    logic                         n_found;
    logic [PW-1:0]                n_best_port;
    logic [SUM_W-1:0]             n_best_sum;
    logic [mcops_pkg::BEST_W-1:0] best_sat;

    // candidate bits beyond the port count drop out, missing eligible bits read zero
    assign cand_ext = CAND_EXT_W'(i_port_candidates);
    assign elig_ext = ELIG_EXT_W'(i_vc_eligible);

    assign wr_cred = (int'(i_status_credits) > MAX_CREDITS) ?
                     mcops_pkg::CRED_W'(MAX_CREDITS) : i_status_credits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PORTS; p++) begin
                r_avail[p] <= '0;
                for (int v = 0; v < NUM_VCS; v++) begin
                    r_cred[p][v] <= '0;
                end
            end
        end else if (i_cmd.write) begin
            // out-of-range port or channel matches no entry
            for (int p = 0; p < NUM_PORTS; p++) begin
                for (int v = 0; v < NUM_VCS; v++) begin
                    if (int'(i_status_port) == p && int'(i_status_vc) == v) begin
                        r_cred[p][v]  <= wr_cred;
                        r_avail[p][v] <= i_status_avail;
                    end
                end
            end
        end
    end

    always_comb begin
        port_sum = '0;
        for (int v = 0; v < NUM_VCS; v++) begin
            if (r_elig[r_port][v] && r_avail[r_port][v]) begin
                port_sum = port_sum + SUM_W'(r_cred[r_port][v]);
            end
        end
    end

    // strict greater keeps the lower port on ties
    assign take        = r_cand[r_port] && (!r_found || port_sum > r_best_sum);
    assign n_found     = r_found | take;
    assign n_best_port = take ? r_port : r_best_port;
    assign n_best_sum  = take ? port_sum : r_best_sum;
    assign best_sat    = (int'(n_best_sum) > mcops_pkg::BEST_MAX) ?
                         mcops_pkg::BEST_W'(mcops_pkg::BEST_MAX) :
                         mcops_pkg::BEST_W'(n_best_sum);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cand <= cand_ext[NUM_PORTS-1:0];
            for (int p = 0; p < NUM_PORTS; p++) begin
                r_elig[p] <= elig_ext[p*NUM_VCS +: NUM_VCS];
            end
            r_port      <= '0;
            r_found     <= 1'b0;
            r_best_port <= '0;
            r_best_sum  <= '0;
        end else if (i_cmd.step) begin
            r_port      <= r_port + PW'(1);
            r_found     <= n_found;
            r_best_port <= n_best_port;
            r_best_sum  <= n_best_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_chosen   <= mcops_pkg::PORT_W'(n_best_port);
            r_best_out <= best_sat;
            r_none     <= !n_found;
        end
    end

    assign o_stat.last    = (r_port == PW'(NUM_PORTS - 1));
    assign o_strobe       = r_strobe;
    assign o_chosen_port  = r_chosen;
    assign o_best_credits = r_best_out;
    assign o_no_candidate = r_none;

endmodule

### sv/most_credit_output_port_select_core.sv
// select beat: accepted, then one port evaluated per cycle; busy while the ports are scanned,
// result strobed in the first cycle busy is low; a new select beat is taken only when idle
// status beat: taken only while idle, written at the accepting edge, no result
// the port counter over the shared sum-and-compare unit sets the select rate
// synchronous active-low reset clears the channel store (zero credits, unavailable)
// and the controller; the result strobe cannot be stalled by the receiver
module most_credit_output_port_select_core #(
    parameter int NUM_PORTS   = 5,
    parameter int NUM_VCS     = 4,
    parameter int MAX_CREDITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_action,
    input  logic [mcops_pkg::CAND_W-1:0] i_port_candidates,
    input  logic [mcops_pkg::ELIG_W-1:0] i_vc_eligible,
    input  logic [mcops_pkg::PORT_W-1:0] i_status_port,
    input  logic [mcops_pkg::VC_W-1:0]   i_status_vc,
    input  logic                         i_status_avail,
    input  logic [mcops_pkg::CRED_W-1:0] i_status_credits,
    output logic                         o_strobe,
    output logic [mcops_pkg::PORT_W-1:0] o_chosen_port,
    output logic [mcops_pkg::BEST_W-1:0] o_best_credits,
    output logic                         o_no_candidate
);

    mcops_pkg::t_dp_cmd  dp_cmd;
    mcops_pkg::t_dp_stat dp_stat;

    mcops_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_stat   (dp_stat),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    mcops_datapath #(
        .NUM_PORTS   (NUM_PORTS),
        .NUM_VCS     (NUM_VCS),
        .MAX_CREDITS (MAX_CREDITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .i_port_candidates (i_port_candidates),
        .i_vc_eligible     (i_vc_eligible),
        .i_status_port     (i_status_port),
        .i_status_vc       (i_status_vc),
        .i_status_avail    (i_status_avail),
        .i_status_credits  (i_status_credits),
        .o_strobe          (o_strobe),
        .o_chosen_port     (o_chosen_port),
        .o_best_credits    (o_best_credits),
        .o_no_candidate    (o_no_candidate)
    );

    // result shows only once the scan is over
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while scan still busy");

    // end of a scan always delivers a result
    a_scan_ends_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_strobe)
        else $error("scan ended without a result");

    // an accepted select beat starts a scan
    a_select_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == mcops_pkg::ACT_SELECT) |=> busy)
        else $error("select beat did not start a scan");

    // an empty candidate set reports port 0 and no credits
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_no_candidate) |-> (o_chosen_port == '0 && o_best_credits == '0))
        else $error("empty candidate result not cleared");

endmodule
